@@ hw/rtl/mbps_pkg.sv @@
// Package with the shared constants and types of the masked byte pattern scanner.
package mbps_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
   localparam int ADDR_W      = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int MASK_W      = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_ADDRESS   = 3'd0,
      CSR_PATTERN_LOW    = 3'd1,
      CSR_PATTERN_HIGH   = 3'd2,
      CSR_MASK_BITS      = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4,
      CSR_FIND_ALL       = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]                base_address;
      logic [MAX_PATTERN-1:0][7:0]      pattern;
      logic [MASK_W-1:0]                mask_bits;
      logic [LEN_W-1:0]                 pattern_length;
      logic                             find_all;
   } scan_cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] match_address;
      logic              found;
      logic              done_res;
   } scan_result_type;

endpackage

@@ hw/rtl/mbps_csr.sv @@
// Configuration registers of the masked byte pattern scanner.
module mbps_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output mbps_pkg::scan_cfg_type             cfg
);

   logic [mbps_pkg::ADDR_W-1:0]  base_ff;
   logic [63:0]                  pat_low_ff;
   logic [63:0]                  pat_high_ff;
   logic [mbps_pkg::MASK_W-1:0]  mask_ff;
   logic [mbps_pkg::LEN_W-1:0]   len_ff;
   logic                         find_all_ff;
   logic                         wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         mask_ff     <= '1;
         len_ff      <= mbps_pkg::LEN_W'(1);
         find_all_ff <= 1'b1;
      end else if (wr_en) begin
         unique case (csr_index)
            mbps_pkg::CSR_BASE_ADDRESS:   base_ff     <= csr_wdata[mbps_pkg::ADDR_W-1:0];
            mbps_pkg::CSR_PATTERN_LOW:    pat_low_ff  <= csr_wdata[63:0];
            mbps_pkg::CSR_PATTERN_HIGH:   pat_high_ff <= csr_wdata[63:0];
            mbps_pkg::CSR_MASK_BITS:      mask_ff     <= csr_wdata[mbps_pkg::MASK_W-1:0];
            mbps_pkg::CSR_PATTERN_LENGTH: len_ff      <= csr_wdata[mbps_pkg::LEN_W-1:0];
            mbps_pkg::CSR_FIND_ALL:       find_all_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.base_address   = base_ff;
   assign cfg.pattern        = {pat_high_ff, pat_low_ff};
   assign cfg.mask_bits      = mask_ff;
   assign cfg.pattern_length = len_ff;
   assign cfg.find_all       = find_all_ff;

endmodule

@@ hw/rtl/mbps_core.sv @@
// Input register, byte window state and masked window compare of the scanner.
module mbps_core (
   input  logic                          clock,
   input  logic                          reset,
   input  mbps_pkg::scan_cfg_type        cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last_byte,
   output logic                          res_valid,
   input  logic                          res_ready,
   output mbps_pkg::scan_result_type     res
);

   logic                                        in_valid_ff;
   logic [7:0]                                  in_byte_ff;
   logic                                        in_last_ff;
   logic [mbps_pkg::MAX_PATTERN-1:0][7:0]       win_ff;
   logic [mbps_pkg::MAX_PATTERN-1:0][7:0]       win_in;
   logic [mbps_pkg::LEN_W-1:0]                  fill_ff;
   logic [mbps_pkg::LEN_W-1:0]                  fill_in;
   logic [mbps_pkg::ADDR_W-1:0]                 pos_ff;
   logic                                        first_ff;
   logic [mbps_pkg::MAX_PATTERN-1:0][7:0]       win_next;
   logic [mbps_pkg::LEN_W-1:0]                  fill_next;
   logic [mbps_pkg::LEN_W-1:0]                  len_eff;
   logic                                        match;
   logic                                        hit;
   logic                                        produce;
   logic                                        advance;

   assign len_eff = (cfg.pattern_length > mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN))
                    ? mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN) : cfg.pattern_length;

   always_comb begin
      win_next[0] = in_byte_ff;
      for (int k = 1; k < mbps_pkg::MAX_PATTERN; k++) begin
         win_next[k] = win_ff[k-1];
      end
      fill_next = (fill_ff < mbps_pkg::LEN_W'(mbps_pkg::MAX_PATTERN))
                  ? fill_ff + mbps_pkg::LEN_W'(1) : fill_ff;
   end

   always_comb begin
      logic [mbps_pkg::LEN_W-1:0] age;
      match = 1'b1;
      age   = '0;
      for (int i = 0; i < mbps_pkg::MAX_PATTERN; i++) begin
         age = len_eff - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
         if ((mbps_pkg::LEN_W'(i) < len_eff) && cfg.mask_bits[i]) begin
            if (win_next[age[mbps_pkg::WIN_IDX_W-1:0]] != cfg.pattern[i]) begin
               match = 1'b0;
            end
         end
      end
   end

   assign hit = (len_eff != '0) && (fill_next >= len_eff) && match
                && (cfg.find_all || !first_ff);
   assign produce   = hit || in_last_ff;
   assign res_valid = in_valid_ff && produce;
   assign advance   = in_valid_ff && (res_ready || !produce);
   assign req_ready = !in_valid_ff || advance;

   assign res.match_address = hit ? (cfg.base_address + pos_ff
                              - mbps_pkg::ADDR_W'(len_eff - mbps_pkg::LEN_W'(1))) : '0;
   assign res.found         = hit;
   assign res.done_res      = in_last_ff;

   always_comb begin
      win_in  = win_next;
      fill_in = (hit && cfg.find_all) ? '0 : fill_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         fill_ff  <= '0;
         pos_ff   <= '0;
         first_ff <= 1'b0;
      end else if (advance) begin
         if (in_last_ff) begin
            win_ff   <= '0;
            fill_ff  <= '0;
            pos_ff   <= '0;
            first_ff <= 1'b0;
         end else begin
            win_ff   <= win_in;
            fill_ff  <= fill_in;
            pos_ff   <= pos_ff + mbps_pkg::ADDR_W'(1);
            first_ff <= first_ff || (hit && !cfg.find_all);
         end
      end
   end

endmodule

@@ hw/rtl/mbps_rsp_reg.sv @@
// Result register between the compare stage and the result channel.
module mbps_rsp_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          res_valid,
   output logic                          res_ready,
   input  mbps_pkg::scan_result_type     res,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [mbps_pkg::ADDR_W-1:0]   rsp_match_address,
   output logic                          rsp_found,
   output logic                          rsp_done_res
);

   logic                            valid_ff;
   mbps_pkg::scan_result_type       data_ff;

   assign res_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (res_ready) begin
         valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         data_ff <= res;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_match_address = data_ff.match_address;
   assign rsp_found         = data_ff.found;
   assign rsp_done_res      = data_ff.done_res;

endmodule

@@ hw/rtl/masked_byte_pattern_scanner_top.sv @@
// Top level of the masked byte pattern scanner.
// The scanner takes one region byte per cycle, a new item every cycle, unless a result stalls.
// An item passes an input register, the masked compare of the 16-byte window, and a
// result register, and its result is offered on the result channel from that result
// register; items that produce no result (no hit and not the last byte) leave
// nothing on the result channel. The result stage holds one finished item while the
// next is compared, and a stalled result stops input only when the compared item also
// has a result. Configuration writes are taken every cycle and must only be made while
// the block is idle. The last byte of a region resets the window, the byte offset and
// the first-hit flag, so the next byte starts a new region at the base address.
module masked_byte_pattern_scanner_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mbps_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mbps_pkg::ADDR_W-1:0]          rsp_match_address,
   output logic                                 rsp_found,
   output logic                                 rsp_done_res
);

   mbps_pkg::scan_cfg_type       cfg;
   mbps_pkg::scan_result_type    res;
   logic                         res_valid;
   logic                         res_ready;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbps_core u_core (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   mbps_rsp_reg u_rsp_reg (
      .clock             (clock),
      .reset             (reset),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res               (res),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_match_address (rsp_match_address),
      .rsp_found         (rsp_found),
      .rsp_done_res      (rsp_done_res)
   );

endmodule
